@@ rtl/core/mcq_pkg.sv @@
package mcq_pkg;

    localparam int RUN_LIMIT = 16;
    localparam logic [15:0] MAX_SIZE_RESET = 16'd1024;

    // byte address of the message limit register
    localparam logic [1:0] ADDR_MAX_SIZE = 2'd0;

    typedef enum logic [1:0] {
        ACT_PUSH  = 2'd0,
        ACT_DRAIN = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NOP   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_TOO_LARGE = 2'd1,
        STS_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_DRAIN,
        CMD_CLEAR,
        CMD_NOP
    } t_cmd_kind;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [15:0] size;
        logic [15:0] tag;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic        chunk_valid;
        logic [15:0] out_tag;
        logic [15:0] out_size;
        logic [15:0] bytes_left;
        logic [4:0]  chunks_left;
        logic        last;
        logic [19:0] buffered_bytes;
        logic        queue_empty;
        logic        can_fill;
    } t_result;

endpackage

@@ rtl/core/mcq_if.sv @@
interface mcq_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [15:0] chunk_size;
    logic [15:0] chunk_tag;

    modport source (output valid, output action, output chunk_size, output chunk_tag,
                    input ready);
    modport sink   (input valid, input action, input chunk_size, input chunk_tag,
                    output ready);
endinterface

interface mcq_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic        chunk_valid;
    logic [15:0] out_tag;
    logic [15:0] out_size;
    logic [15:0] bytes_left_in_message;
    logic [4:0]  chunks_left_in_message;
    logic        last;
    logic [19:0] buffered_bytes;
    logic        queue_empty;
    logic        can_fill;

    modport source (output valid, output status, output chunk_valid, output out_tag,
                    output out_size, output bytes_left_in_message,
                    output chunks_left_in_message, output last, output buffered_bytes,
                    output queue_empty, output can_fill, input ready);
    modport sink   (input valid, input status, input chunk_valid, input out_tag,
                    input out_size, input bytes_left_in_message,
                    input chunks_left_in_message, input last, input buffered_bytes,
                    input queue_empty, input can_fill, output ready);
endinterface

@@ rtl/core/mcq_front.sv @@
module mcq_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mcq_in_if.sink        i_in,
    output mcq_pkg::t_cmd o_cmd,
    output logic          o_cmd_valid,
    input  logic          i_cmd_pop
);
    import mcq_pkg::*;

    t_cmd       cmd_in;
    t_cmd       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_fill;
    logic       push;

    always_comb begin
        cmd_in = '0;
        unique case (i_in.action)
            ACT_PUSH: begin
                cmd_in.kind = CMD_PUSH;
                cmd_in.size = i_in.chunk_size;
                cmd_in.tag  = i_in.chunk_tag;
            end
            ACT_DRAIN: cmd_in.kind = CMD_DRAIN;
            ACT_CLEAR: cmd_in.kind = CMD_CLEAR;
            default:   cmd_in.kind = CMD_NOP;
        endcase
    end

    assign i_in.ready  = (r_fill != 2'd2);
    assign push        = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_fill != 2'd0);
    assign o_cmd       = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= cmd_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_cmd_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({push, i_cmd_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

@@ rtl/core/mcq_back.sv @@
module mcq_back #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [15:0]   i_max_size,
    input  mcq_pkg::t_cmd i_cmd,
    input  logic          i_cmd_valid,
    output logic          o_cmd_pop,
    mcq_out_if.source     o_out
);
    import mcq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TOT_W = $clog2(QUEUE_DEPTH * 65535 + 1);
    localparam int CMP_W = (CNT_W > 5) ? CNT_W : 5;

    logic [TAG_BITS-1:0] r_tag_mem  [QUEUE_DEPTH];
    logic [15:0]         r_size_mem [QUEUE_DEPTH];
    logic [TAG_BITS-1:0] r_rd_tag;
    logic [15:0]         r_rd_size;
    logic                mem_we;

    t_state              r_state, n_state;
    logic [IDX_W-1:0]    r_head, n_head;
    logic [IDX_W-1:0]    r_tail, n_tail;
    logic [IDX_W-1:0]    r_ptr, n_ptr;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [TOT_W-1:0]    r_total, n_total;
    logic [15:0]         r_cum, n_cum;
    logic [4:0]          r_run, n_run;
    logic [4:0]          r_scan, n_scan;

    logic                r_out_valid;
    t_result             r_out;
    t_result             res;
    logic                produce;

    logic                out_free;
    logic [16:0]         sum;
    logic                fits;
    logic [4:0]          scanned;
    logic                stop_cnt;
    logic                scan_stop;
    logic [15:0]         scan_final;
    logic [15:0]         rem;
    logic                take_cmd;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    endfunction

    // shared conditions for the sequencer and the datapath
    always_comb begin
        out_free   = !r_out_valid || o_out.ready;
        take_cmd   = i_cmd_valid && out_free;
        sum        = {1'b0, r_cum} + {1'b0, r_rd_size};
        fits       = (sum <= {1'b0, i_max_size});
        scanned    = r_scan + 5'd1;
        stop_cnt   = (CMP_W'(scanned) == CMP_W'(RUN_LIMIT))
                  || (CMP_W'(scanned) == CMP_W'(r_count));
        scan_stop  = !fits || stop_cnt;
        scan_final = fits ? sum[15:0] : r_cum;
        rem        = r_cum - r_rd_size;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (take_cmd && i_cmd.kind == CMD_DRAIN && r_count != '0) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (scan_stop) begin
                    if (scan_final != 16'd0) begin
                        n_state = S_EMIT;
                    end else if (out_free) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (out_free && rem == 16'd0) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_ptr     = r_ptr;
        n_count   = r_count;
        n_total   = r_total;
        n_cum     = r_cum;
        n_run     = r_run;
        n_scan    = r_scan;
        o_cmd_pop = 1'b0;
        mem_we    = 1'b0;
        produce   = 1'b0;
        res       = '0;
        res.status = STS_OK;
        res.last   = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (take_cmd) begin
                    o_cmd_pop = 1'b1;
                    unique case (i_cmd.kind)
                        CMD_PUSH: begin
                            produce = 1'b1;
                            if (i_cmd.size > i_max_size) begin
                                res.status = STS_TOO_LARGE;
                            end else if (r_count == CNT_W'(QUEUE_DEPTH)) begin
                                res.status = STS_FULL;
                            end else begin
                                mem_we  = 1'b1;
                                n_tail  = idx_inc(r_tail);
                                n_count = r_count + 1'b1;
                                n_total = r_total + TOT_W'(i_cmd.size);
                            end
                        end
                        CMD_CLEAR: begin
                            produce = 1'b1;
                            n_head  = '0;
                            n_tail  = '0;
                            n_count = '0;
                            n_total = '0;
                        end
                        CMD_DRAIN: begin
                            if (r_count == '0) begin
                                produce = 1'b1;
                            end else begin
                                n_ptr  = r_head;
                                n_scan = '0;
                                n_cum  = '0;
                                n_run  = '0;
                            end
                        end
                        default: produce = 1'b1;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_stop) begin
                    if (scan_final != 16'd0) begin
                        n_cum = scan_final;
                        n_run = fits ? r_run + 5'd1 : r_run;
                        n_ptr = r_head;
                    end else if (out_free) begin
                        // run holds no bytes: nothing leaves the queue
                        produce = 1'b1;
                    end
                end else begin
                    n_cum  = sum[15:0];
                    n_run  = r_run + 5'd1;
                    n_scan = scanned;
                    n_ptr  = idx_inc(r_ptr);
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    produce         = 1'b1;
                    res.chunk_valid = 1'b1;
                    res.out_tag     = 16'(r_rd_tag);
                    res.out_size    = r_rd_size;
                    res.bytes_left  = rem;
                    res.chunks_left = r_run - 5'd1;
                    res.last        = (rem == 16'd0);
                    n_cum           = rem;
                    n_run           = r_run - 5'd1;
                    n_total         = (r_total >= TOT_W'(r_rd_size))
                                    ? r_total - TOT_W'(r_rd_size) : '0;
                    n_head          = idx_inc(r_head);
                    n_ptr           = idx_inc(r_head);
                    n_count         = r_count - 1'b1;
                end
            end
            default: ;
        endcase

        res.buffered_bytes = 20'(n_total);
        res.queue_empty    = (n_count == '0);
        res.can_fill       = (n_total >= TOT_W'(i_max_size));
    end

    // read port follows the next pointer so data lines up with r_ptr
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_tag_mem[r_tail]  <= TAG_BITS'(i_cmd.tag);
            r_size_mem[r_tail] <= i_cmd.size;
        end
        r_rd_tag  <= r_tag_mem[n_ptr];
        r_rd_size <= r_size_mem[n_ptr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_ptr       <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_cum       <= '0;
            r_run       <= '0;
            r_scan      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_ptr   <= n_ptr;
            r_count <= n_count;
            r_total <= n_total;
            r_cum   <= n_cum;
            r_run   <= n_run;
            r_scan  <= n_scan;
            if (produce) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (produce) begin
            r_out <= res;
        end
    end

    assign o_out.valid                  = r_out_valid;
    assign o_out.status                 = r_out.status;
    assign o_out.chunk_valid            = r_out.chunk_valid;
    assign o_out.out_tag                = r_out.out_tag;
    assign o_out.out_size               = r_out.out_size;
    assign o_out.bytes_left_in_message  = r_out.bytes_left;
    assign o_out.chunks_left_in_message = r_out.chunks_left;
    assign o_out.last                   = r_out.last;
    assign o_out.buffered_bytes         = r_out.buffered_bytes;
    assign o_out.queue_empty            = r_out.queue_empty;
    assign o_out.can_fill               = r_out.can_fill;

endmodule

@@ rtl/core/message_chunk_coalescing_queue_core.sv @@
// push/clear/no-op: front slot, then result register; one per cycle while output ready
// drain: n chunks scanned from the queue memory one per cycle, then k chunks emitted one
// per cycle while the output is ready; the queue memory's single read port paces the scan
// a two-entry command queue lets the input side take items while the back end is busy
// reset (synchronous, active low) empties the queue and loads a message limit of 1024
module message_chunk_coalescing_queue_core #(
    parameter int QUEUE_DEPTH = 16,
    parameter int TAG_BITS    = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mcq_in_if.sink      i_in,
    mcq_out_if.source   o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mcq_pkg::*;

    logic [15:0] r_max_size;
    t_cmd        cmd;
    logic        cmd_valid;
    logic        cmd_pop;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_MAX_SIZE);
    assign prdata = (paddr == ADDR_MAX_SIZE) ? {16'd0, r_max_size} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_size <= MAX_SIZE_RESET;
        end else if (cfg_wr) begin
            r_max_size <= pwdata[15:0];
        end
    end

    mcq_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    mcq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .TAG_BITS    (TAG_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_size  (r_max_size),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_out       (o_out)
    );

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import mcq_pkg::*;

    localparam int QDEPTH        = 16;
    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;

    typedef struct {
        t_action     act;
        logic [15:0] size;
        logic [15:0] tag;
    } t_chunk_cmd;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [1:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    mcq_in_if  in_if ();
    mcq_out_if out_if ();

    message_chunk_coalescing_queue_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 i_clk = ~i_clk;

    // commands waiting to be driven, results the queue should produce
    t_chunk_cmd cmd_backlog[$];
    t_result    expected_results[$];
    t_chunk_cmd cmd_on_bus;
    int         cmds_queued = 0;
    int         cmds_taken = 0;
    int         err_count = 0;
    int         quiet_cycles = 0;
    int         send_idle_pct = 0;
    int         recv_stall_pct = 0;

    // shadow of the coalescing queue
    logic [15:0] q_tag [QDEPTH];
    logic [15:0] q_size [QDEPTH];
    int unsigned q_head = 0;
    int unsigned q_tail = 0;
    int unsigned q_count = 0;
    int unsigned q_bytes = 0;
    logic [15:0] msg_limit = MAX_SIZE_RESET;

    function automatic t_result make_result(t_status st, logic cv, logic [15:0] tag,
                                            logic [15:0] size, logic [15:0] left,
                                            logic [4:0] nleft, logic lst);
        t_result r;
        r.status         = st;
        r.chunk_valid    = cv;
        r.out_tag        = tag;
        r.out_size       = size;
        r.bytes_left     = left;
        r.chunks_left    = nleft;
        r.last           = lst;
        r.buffered_bytes = q_bytes[19:0];
        r.queue_empty    = (q_count == 0);
        r.can_fill       = (q_bytes >= msg_limit);
        return r;
    endfunction

    task automatic predict_queue_op(input t_chunk_cmd c);
        t_status     st;
        int unsigned run_bytes;
        int unsigned run_len;
        int unsigned rem;
        int unsigned s;
        logic [15:0] t;
        logic        lst;
        int          k;
        case (c.act)
            ACT_PUSH: begin
                st = STS_OK;
                if (c.size > msg_limit) begin
                    st = STS_TOO_LARGE;
                end else if (q_count >= QDEPTH) begin
                    st = STS_FULL;
                end else begin
                    q_tag[q_tail]  = c.tag;
                    q_size[q_tail] = c.size;
                    q_tail  = (q_tail + 1) % QDEPTH;
                    q_count = q_count + 1;
                    q_bytes = q_bytes + c.size;
                end
                expected_results.push_back(make_result(st, 1'b0, '0, '0, '0, '0, 1'b1));
            end
            ACT_CLEAR: begin
                q_head  = 0;
                q_tail  = 0;
                q_count = 0;
                q_bytes = 0;
                expected_results.push_back(make_result(STS_OK, 1'b0, '0, '0, '0, '0, 1'b1));
            end
            ACT_DRAIN: begin
                run_bytes = 0;
                run_len   = 0;
                for (int i = 0; i < RUN_LIMIT; i++) begin
                    if (i >= q_count) break;
                    s = q_size[(q_head + i) % QDEPTH];
                    if (run_bytes + s > msg_limit) break;
                    run_bytes = run_bytes + s;
                    run_len   = run_len + 1;
                end
                if (run_bytes == 0) begin
                    // nothing to send: empty queue, oversized head or only zero-size chunks
                    expected_results.push_back(make_result(STS_OK, 1'b0, '0, '0, '0, '0, 1'b1));
                end else begin
                    k = 0;
                    while (run_bytes > 0 && q_count > 0 && run_len > 0 && k < RUN_LIMIT) begin
                        s   = q_size[q_head];
                        t   = q_tag[q_head];
                        rem = (run_bytes >= s) ? run_bytes - s : 0;
                        run_len   = run_len - 1;
                        run_bytes = rem;
                        q_bytes   = (q_bytes >= s) ? q_bytes - s : 0;
                        q_head    = (q_head + 1) % QDEPTH;
                        q_count   = q_count - 1;
                        lst = (rem == 0) || (q_count == 0) || (run_len == 0)
                              || (k == RUN_LIMIT - 1);
                        expected_results.push_back(make_result(STS_OK, 1'b1, t, s[15:0],
                                                               rem[15:0], run_len[4:0], lst));
                        k++;
                    end
                end
            end
            default: begin
                expected_results.push_back(make_result(STS_OK, 1'b0, '0, '0, '0, '0, 1'b1));
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        if (err_count < 200) $display("mismatch: %s", msg);
        err_count++;
    endtask

    task automatic check_field(input string name, input logic [19:0] got,
                               input logic [19:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid      <= 1'b0;
            in_if.action     <= ACT_NOP;
            in_if.chunk_size <= '0;
            in_if.chunk_tag  <= '0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                predict_queue_op(cmd_on_bus);
                cmds_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    cmd_on_bus = cmd_backlog.pop_front();
                    in_if.valid      <= 1'b1;
                    in_if.action     <= cmd_on_bus.act;
                    in_if.chunk_size <= cmd_on_bus.size;
                    in_if.chunk_tag  <= cmd_on_bus.tag;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got.status         = t_status'(out_if.status);
                got.chunk_valid    = out_if.chunk_valid;
                got.out_tag        = out_if.out_tag;
                got.out_size       = out_if.out_size;
                got.bytes_left     = out_if.bytes_left_in_message;
                got.chunks_left    = out_if.chunks_left_in_message;
                got.last           = out_if.last;
                got.buffered_bytes = out_if.buffered_bytes;
                got.queue_empty    = out_if.queue_empty;
                got.can_fill       = out_if.can_fill;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("unexpected result tag 0x%0h size %0d",
                                              got.out_tag, got.out_size));
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", 20'(got.status), 20'(want.status));
                    check_field("chunk_valid", 20'(got.chunk_valid), 20'(want.chunk_valid));
                    check_field("out_tag", 20'(got.out_tag), 20'(want.out_tag));
                    check_field("out_size", 20'(got.out_size), 20'(want.out_size));
                    check_field("bytes_left", 20'(got.bytes_left), 20'(want.bytes_left));
                    check_field("chunks_left", 20'(got.chunks_left), 20'(want.chunks_left));
                    check_field("last", 20'(got.last), 20'(want.last));
                    check_field("buffered_bytes", got.buffered_bytes, want.buffered_bytes);
                    check_field("queue_empty", 20'(got.queue_empty), 20'(want.queue_empty));
                    check_field("can_fill", 20'(got.can_fill), 20'(want.can_fill));
                end
            end
            out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // watchdog on cycles without any item moving
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_cmd(input t_action act, input logic [15:0] size,
                           input logic [15:0] tag);
        t_chunk_cmd c;
        c.act  = act;
        c.size = size;
        c.tag  = tag;
        cmd_backlog.push_back(c);
        cmds_queued++;
    endtask

    // sender holds off until every queued item has been taken and answered
    task automatic wait_drained();
        do @(posedge i_clk);
        while (cmds_taken != cmds_queued || expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_max_size(input logic [15:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_MAX_SIZE;
        pwdata  <= {16'd0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        msg_limit = val;
    endtask

    function automatic logic [15:0] pick_size();
        int unsigned lim;
        int unsigned r;
        lim = msg_limit;
        r = $urandom_range(0, 99);
        if (r < 15) return 16'd0;
        if (r < 25) return lim[15:0];
        if (r < 75) return 16'($urandom_range(1, (lim / 4 > 1) ? lim / 4 : 1));
        return 16'($urandom_range(0, lim));
    endfunction

    task automatic gen_random_phase(input int n_items);
        int added;
        int r;
        int burst;
        added = 0;
        while (added < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                // well-formed: a burst of chunks then one or two drains
                burst = $urandom_range(1, 18);
                repeat (burst) add_cmd(ACT_PUSH, pick_size(), 16'($urandom_range(0, 65535)));
                repeat ($urandom_range(1, 2))
                    add_cmd(ACT_DRAIN, 16'($urandom), 16'($urandom));
                added += burst + 2;
            end else if (r < 80) begin
                add_cmd(ACT_CLEAR, 16'($urandom), 16'($urandom));
                added++;
            end else if (r < 90) begin
                if (msg_limit < 16'hFFFF)
                    add_cmd(ACT_PUSH, 16'($urandom_range(msg_limit + 1, 65535)),
                            16'($urandom));
                else
                    add_cmd(ACT_PUSH, 16'($urandom), 16'($urandom));
                added++;
            end else begin
                add_cmd(t_action'($urandom_range(0, 3)), 16'($urandom), 16'($urandom));
                added++;
            end
        end
    endtask

    initial begin
        int lim_tab [5];
        int send_tab [5];
        int recv_tab [5];
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset limit of 1024
        add_cmd(ACT_DRAIN, 16'd0, 16'd0);          // drain of an empty queue
        add_cmd(ACT_PUSH, 16'd5, 16'h0001);
        add_cmd(ACT_PUSH, 16'd0, 16'h0002);
        add_cmd(ACT_DRAIN, 16'd0, 16'd0);          // zero-size chunk stays behind
        add_cmd(ACT_DRAIN, 16'd0, 16'd0);          // only zero-size left, nothing sent
        add_cmd(ACT_PUSH, 16'd1024, 16'hFFFF);
        add_cmd(ACT_PUSH, 16'd1025, 16'h0000);
        add_cmd(ACT_PUSH, 16'hFFFF, 16'hFFFF);
        add_cmd(ACT_NOP, 16'hFFFF, 16'hFFFF);
        add_cmd(ACT_DRAIN, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < QDEPTH; i++)
            add_cmd(ACT_PUSH, 16'd64, 16'(i * 16'h1111));
        add_cmd(ACT_PUSH, 16'd1, 16'hABCD);        // queue full
        add_cmd(ACT_DRAIN, 16'd0, 16'd0);          // longest run
        add_cmd(ACT_PUSH, 16'd500, 16'h5A5A);
        wait_drained();
        write_max_size(16'd100);
        add_cmd(ACT_DRAIN, 16'd0, 16'd0);          // head above lowered limit
        add_cmd(ACT_CLEAR, 16'hFFFF, 16'hFFFF);
        wait_drained();

        lim_tab  = '{65535, 1, $urandom_range(2, 65534), 300, 1024};
        send_tab = '{0, 53, 0, 27, 0};
        recv_tab = '{0, 0, 53, 27, 0};
        for (int p = 0; p < 5; p++) begin
            write_max_size(16'(lim_tab[p]));
            send_idle_pct  = send_tab[p];
            recv_stall_pct = recv_tab[p];
            gen_random_phase(100);
            wait_drained();
        end

        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

@@ message_chunk_coalescing_queue_core.f @@
rtl/core/mcq_pkg.sv
rtl/core/mcq_if.sv
rtl/core/mcq_front.sv
rtl/core/mcq_back.sv
rtl/core/message_chunk_coalescing_queue_core.sv
sim/tb_top.sv
